[rtl/rmbd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RGBA mipmap box downsampler.
package rmbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int SIZE_W     = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = $clog2(PAIR_DEPTH);

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 8;
  localparam int PAIR_W     = CH_W + 1;
  localparam int QUAD_W     = CH_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] alpha_out;
    logic            frame_last;
  } out_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0]   pix_t;
  typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [SLOT_W-1:0] addr;
  } lb_ctl_t;

  // Out-of-range sizes: zero acts as one, anything above the maximum as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/rmbd_lane.sv]
`timescale 1ns / 1ps
// One color channel lane: horizontal pair sum and final 2x2 truncated average.
module rmbd_lane (
  input  logic [rmbd_pkg::CH_W-1:0]   hold_in,
  input  logic [rmbd_pkg::CH_W-1:0]   px_in,
  output logic [rmbd_pkg::PAIR_W-1:0] pair_sum,
  input  logic [rmbd_pkg::PAIR_W-1:0] upper_pair,
  input  logic [rmbd_pkg::CH_W-1:0]   s1_hold,
  input  logic [rmbd_pkg::CH_W-1:0]   s1_px,
  output logic [rmbd_pkg::CH_W-1:0]   avg
);

  logic [rmbd_pkg::QUAD_W-1:0] quad_sum;

  assign pair_sum = {1'b0, hold_in} + {1'b0, px_in};

  assign quad_sum = {1'b0, upper_pair} + {2'b00, s1_hold} + {2'b00, s1_px};
  // Divide by four and truncate.
  assign avg      = quad_sum[rmbd_pkg::QUAD_W-1:2];

endmodule

[rtl/rmbd_line_buf.sv]
`timescale 1ns / 1ps
// Line buffer holding the per-column pair sums of the last even row.
module rmbd_line_buf (
  input  logic                    clk,
  input  rmbd_pkg::lb_ctl_t       ctl,
  input  rmbd_pkg::pair_t         wr_data,
  output rmbd_pkg::pair_t         rd_data
);

  rmbd_pkg::pair_t mem [rmbd_pkg::PAIR_DEPTH];
  rmbd_pkg::pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rgba_mipmap_box_downsample.sv]
`timescale 1ns / 1ps
// Top level of the RGBA mipmap 2x2 box downsampler.
//
//   Channel  Handshake          Payload                      Direction
//   in_      in_valid/in_stall  in_data  (rmbd_pkg::in_t)    source pixel in
//   out_     out_valid/out_stall out_data (rmbd_pkg::out_t)  averaged pixel out
//   cfg_     cfg_we             cfg_index, cfg_data          size register write
//
// One source pixel is accepted per cycle when the output side keeps up. The
// transaction that completes a block loads the second stage and starts the
// registered line buffer read; the lane sums then go into the output
// register. Reset (rst_n low, synchronous) sets the size to 2x2 and restarts
// the frame; the line buffer needs no clearing pass because every odd row
// only reads entries written on the row before it. When out_stall holds a
// result, in_stall rises only once the second stage is also occupied.
module rgba_mipmap_box_downsample (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rmbd_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rmbd_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [rmbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmbd_pkg::SIZE_W-1:0]        cfg_data
);

  // Effective (already clamped) frame size.
  logic [rmbd_pkg::SIZE_W-1:0] width_r,  width_nxt;
  logic [rmbd_pkg::SIZE_W-1:0] height_r, height_nxt;

  // Position of the next pixel.
  logic [rmbd_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [rmbd_pkg::ROW_W-1:0]  row_r, row_nxt;

  // Even-column pixel waiting for its right neighbor.
  rmbd_pkg::pix_t              hold_r, hold_nxt;

  // Second stage: a block whose line buffer read is in flight.
  logic                        s1_valid_r, s1_valid_nxt;
  rmbd_pkg::pix_t              s1_hold_r;
  rmbd_pkg::pix_t              s1_px_r;
  logic                        s1_last_r;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  rmbd_pkg::out_t              out_data_r;

  rmbd_pkg::pix_t              px;
  rmbd_pkg::pair_t             pair_sum;
  rmbd_pkg::pair_t             upper_pair;
  rmbd_pkg::pix_t              avg;
  rmbd_pkg::lb_ctl_t           lb_ctl;

  logic                        accept;
  logic                        out_free;
  logic                        s1_adv;
  logic                        s1_free;
  logic                        col_odd;
  logic                        row_odd;
  logic                        emit;
  logic                        frame_last;
  logic [rmbd_pkg::SIZE_W-1:0] col_inc;
  logic [rmbd_pkg::SIZE_W-1:0] row_inc;
  logic [rmbd_pkg::SIZE_W-1:0] last_col;
  logic [rmbd_pkg::SIZE_W-1:0] last_row;

  // Channel order inside the lanes: red, green, blue, alpha.
  assign px[0] = in_data.red_in;
  assign px[1] = in_data.green_in;
  assign px[2] = in_data.blue_in;
  assign px[3] = in_data.alpha_in;

  // Handshake: a block moves out of stage one only when the output register
  // is free or is being emptied in the same cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || s1_adv;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  assign emit     = accept && col_odd && row_odd;

  // Last column and row that close a block; for a size of one these wrap to
  // all ones and never match.
  assign last_col = {width_r[rmbd_pkg::SIZE_W-1:1], 1'b0} - rmbd_pkg::SIZE_W'(1);
  assign last_row = {height_r[rmbd_pkg::SIZE_W-1:1], 1'b0} - rmbd_pkg::SIZE_W'(1);
  assign frame_last = (rmbd_pkg::SIZE_W'(col_r) == last_col) &&
                      (rmbd_pkg::SIZE_W'(row_r) == last_row);

  assign col_inc = rmbd_pkg::SIZE_W'(col_r) + rmbd_pkg::SIZE_W'(1);
  assign row_inc = rmbd_pkg::SIZE_W'(row_r) + rmbd_pkg::SIZE_W'(1);

  // Even rows store the pair sum of each column pair; odd rows read it back.
  assign lb_ctl.wr_en = accept && col_odd && !row_odd;
  assign lb_ctl.rd_en = emit;
  assign lb_ctl.addr  = col_r[rmbd_pkg::COL_W-1:1];

  rmbd_line_buf u_line_buf (
    .clk     (clk),
    .ctl     (lb_ctl),
    .wr_data (pair_sum),
    .rd_data (upper_pair)
  );

  for (genvar g = 0; g < rmbd_pkg::NUM_CH; g++) begin : g_lane
    rmbd_lane u_lane (
      .hold_in    (hold_r[g]),
      .px_in      (px[g]),
      .pair_sum   (pair_sum[g]),
      .upper_pair (upper_pair[g]),
      .s1_hold    (s1_hold_r[g]),
      .s1_px      (s1_px_r[g]),
      .avg        (avg[g])
    );
  end

  // Position counters, size registers and the held pixel.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    hold_nxt   = hold_r;
    if (cfg_we) begin
      // Any valid register write restarts the frame.
      case (cfg_index)
        rmbd_pkg::REG_SRC_WIDTH: begin
          width_nxt = rmbd_pkg::clamp_size(cfg_data, rmbd_pkg::SIZE_W'(rmbd_pkg::MAX_WIDTH));
          col_nxt   = '0;
          row_nxt   = '0;
        end
        rmbd_pkg::REG_SRC_HEIGHT: begin
          height_nxt = rmbd_pkg::clamp_size(cfg_data,
                                            rmbd_pkg::SIZE_W'(rmbd_pkg::MAX_HEIGHT));
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (!col_odd) begin
        hold_nxt = px;
      end
      if (col_inc >= width_r) begin
        col_nxt = '0;
        if (row_inc >= height_r) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_inc[rmbd_pkg::ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[rmbd_pkg::COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (emit) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= rmbd_pkg::SIZE_W'(2);
      height_r    <= rmbd_pkg::SIZE_W'(2);
      col_r       <= '0;
      row_r       <= '0;
      hold_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      hold_r      <= hold_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_hold_r <= hold_r;
      s1_px_r   <= px;
      s1_last_r <= frame_last;
    end
    if (s1_adv) begin
      out_data_r.red_out    <= avg[0];
      out_data_r.green_out  <= avg[1];
      out_data_r.blue_out   <= avg[2];
      out_data_r.alpha_out  <= avg[3];
      out_data_r.frame_last <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/rmbd_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the downsampler and its bind statement.
module rmbd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rmbd_pkg::out_t out_data
);

  // A held result keeps its valid and its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed while stalled");

  // Input back-pressure only ever comes from a stalled, occupied output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A fresh result always traces back to an accepted input transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching input transaction");

  // The output register is empty right after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rgba_mipmap_box_downsample rmbd_checker u_rmbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
